@@ rtl/ttms_pkg.sv @@
package ttms_pkg;

    // Width of the delay counters and timers, in bits.
    localparam int DELAY_WIDTH = 16;
    localparam longint DELAY_MAX = (64'd1 << DELAY_WIDTH) - 64'd1;

    // Item actions.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_MODE = 2'd1;
    localparam logic [1:0] ACT_CUE  = 2'd2;

    // Mode codes.
    localparam logic [3:0] MODE_STOP  = 4'd0;
    localparam logic [3:0] MODE_PAUSE = 4'd1;
    localparam logic [3:0] MODE_PLAYF = 4'd2;
    localparam logic [3:0] MODE_REC   = 4'd3;
    localparam logic [3:0] MODE_PLAYR = 4'd4;
    localparam logic [3:0] MODE_FFD   = 4'd5;
    localparam logic [3:0] MODE_REW   = 4'd6;
    localparam logic [3:0] MODE_AFFD  = 4'd7;
    localparam logic [3:0] MODE_AREW  = 4'd8;
    localparam logic [3:0] MODE_CAPF  = 4'd9;
    localparam logic [3:0] MODE_CAPR  = 4'd10;
    localparam logic [3:0] MODE_ASTOP = 4'd11;
    localparam logic [3:0] SEQ_FFFD   = 4'd12;
    localparam logic [3:0] SEQ_FREW   = 4'd13;
    localparam logic [3:0] MODE_NONE  = 4'd15;

    // Autostop modes.
    localparam logic [2:0] AS_OFF     = 3'd0;
    localparam logic [2:0] AS_SPINUP  = 3'd1;
    localparam logic [2:0] AS_PLAY    = 3'd2;
    localparam logic [2:0] AS_FFD     = 3'd3;
    localparam logic [2:0] AS_REW     = 3'd4;
    localparam logic [2:0] AS_BRAKING = 3'd5;

    // Mute argument that follows the cue setting.
    localparam logic [3:0] MUTE_NOTCUE = 4'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLES  = 2'd0;
    localparam logic [1:0] REG_PRETENS  = 2'd1;
    localparam logic [1:0] REG_TENSION  = 2'd2;
    localparam logic [1:0] REG_BRAKE    = 2'd3;

    typedef enum logic [3:0] {
        K_MUTE  = 4'd0,
        K_CAP   = 4'd1,
        K_PRESS = 4'd2,
        K_SPOOL = 4'd3,
        K_AS    = 4'd4,
        K_WSTOP = 4'd5,
        K_LIFT  = 4'd6,
        K_BRAKE = 4'd7,
        K_WTEN  = 4'd8,
        K_WCAP  = 4'd9,
        K_FINAL = 4'd10
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  arg;
        logic [8:0]  del;
    } seq_op_t;

    typedef struct packed {
        logic        press;
        logic        brake;
        logic        lift;
        logic        reverse;
        logic [2:0]  spool;
        logic        mute;
        logic [3:0]  active;
        logic        trip;
        logic        low_ten;
    } result_t;

    function automatic seq_op_t mk(op_kind_t k, logic [3:0] a, logic [8:0] d);
        seq_op_t o;
        o.kind = k;
        o.arg  = a;
        o.del  = d;
        return o;
    endfunction

    // Load a delay into a counter, saturating at the counter maximum.
    function automatic logic [DELAY_WIDTH-1:0] sat_load(logic [15:0] v);
        if (64'(v) > 64'(DELAY_MAX))
            return '1;
        else
            return DELAY_WIDTH'(64'(v));
    endfunction

    // Number of operations in each sequence.
    function automatic logic [4:0] seq_len(logic [3:0] seq);
        logic [4:0] n;
        unique case (seq) inside
            MODE_STOP, MODE_PAUSE:               n = 5'd11;
            MODE_PLAYF, MODE_REC, MODE_PLAYR:    n = 5'd17;
            MODE_FFD, MODE_REW:                  n = 5'd13;
            MODE_AFFD, MODE_AREW:                n = 5'd14;
            MODE_CAPF, MODE_CAPR:                n = 5'd5;
            MODE_ASTOP:                          n = 5'd9;
            SEQ_FFFD, SEQ_FREW:                  n = 5'd4;
            default:                             n = 5'd0;
        endcase
        return n;
    endfunction

    // Sequence ROM, indexed by sequence and step (step counts from one).
    function automatic seq_op_t seq_rom(logic [3:0] seq, logic [4:0] step);
        seq_op_t o;
        logic [3:0] sp;
        o  = mk(K_FINAL, MODE_NONE, 9'd0);
        sp = 4'd0;
        unique case (seq) inside
            MODE_STOP, MODE_PAUSE:
            begin
                unique case (step)
                    5'd1:    o = mk(K_MUTE, 4'd1, 9'd10);
                    5'd2:    o = mk(K_PRESS, 4'd0, 9'd100);
                    5'd3:    o = mk(K_SPOOL, 4'd1, 9'd0);
                    5'd4:    o = mk(K_AS, 4'(AS_BRAKING), 9'd0);
                    5'd5:    o = mk(K_WSTOP, 4'd0, 9'd0);
                    5'd6:    o = mk(K_AS, 4'(AS_OFF), 9'd0);
                    5'd7:    o = mk(K_LIFT, 4'd0, 9'd400);
                    5'd8:    o = mk(K_BRAKE, 4'd0, 9'd100);
                    5'd9:    o = mk(K_SPOOL, 4'd0, 9'd100);
                    5'd10:   o = mk(K_MUTE, MUTE_NOTCUE, 9'd0);
                    default: o = mk(K_FINAL, MODE_NONE, 9'd0);
                endcase
            end
            MODE_PLAYF, MODE_REC, MODE_PLAYR:
            begin
                unique case (step)
                    5'd1:    o = mk(K_MUTE, 4'd1, 9'd10);
                    5'd2:    o = mk(K_CAP, (seq == MODE_PLAYR) ? 4'd1 : 4'd0, 9'd0);
                    5'd3:    o = mk(K_PRESS, 4'd0, 9'd100);
                    5'd4:    o = mk(K_SPOOL, 4'd1, 9'd0);
                    5'd5:    o = mk(K_AS, 4'(AS_BRAKING), 9'd0);
                    5'd6:    o = mk(K_WSTOP, 4'd0, 9'd0);
                    5'd7:    o = mk(K_AS, 4'(AS_OFF), 9'd0);
                    5'd8:    o = mk(K_LIFT, 4'd0, 9'd400);
                    5'd9:    o = mk(K_BRAKE, 4'd1,
                                    (seq == MODE_PLAYR) ? 9'd50 : 9'd100);
                    5'd10:   o = mk(K_AS, 4'(AS_SPINUP), 9'd0);
                    5'd11:   o = mk(K_WTEN, 4'd0, 9'd0);
                    5'd12:   o = mk(K_WCAP, 4'd0, 9'd0);
                    5'd13:   o = mk(K_AS, 4'(AS_PLAY), 9'd0);
                    5'd14:   o = mk(K_SPOOL, (seq == MODE_PLAYR) ? 4'd3 : 4'd2, 9'd0);
                    5'd15:   o = mk(K_PRESS, 4'd1, 9'd300);
                    5'd16:   o = mk(K_MUTE, 4'd0, 9'd0);
                    default: o = mk(K_FINAL, MODE_NONE, 9'd0);
                endcase
            end
            MODE_FFD, MODE_REW, MODE_AFFD, MODE_AREW:
            begin
                // Spool code per mode: ffd 4, rew 5, affd 6, arew 7.
                sp = seq - 4'd1;
                unique case (step)
                    5'd1:    o = mk(K_MUTE, 4'd1, 9'd20);
                    5'd2:    o = mk(K_PRESS, 4'd0, 9'd100);
                    5'd3:    o = mk(K_SPOOL, 4'd1, 9'd0);
                    5'd4:    o = mk(K_AS, 4'(AS_BRAKING), 9'd0);
                    5'd5:    o = mk(K_WSTOP, 4'd0, 9'd0);
                    5'd6:    o = mk(K_AS, 4'(AS_OFF), 9'd0);
                    5'd7:    o = mk(K_BRAKE, 4'd1, 9'd100);
                    5'd8:    o = mk(K_AS, 4'(AS_SPINUP), 9'd0);
                    5'd9:    o = mk(K_WTEN, 4'd0, 9'd0);
                    5'd10:   o = mk(K_LIFT, 4'd1, 9'd100);
                    5'd11:   o = mk(K_SPOOL, sp,
                                    (seq == MODE_AFFD || seq == MODE_AREW) ?
                                    9'd100 : 9'd0);
                    5'd12:   o = mk(K_AS, (seq == MODE_FFD || seq == MODE_AFFD) ?
                                    4'(AS_FFD) : 4'(AS_REW), 9'd0);
                    5'd13:   o = (seq == MODE_AFFD || seq == MODE_AREW) ?
                                 mk(K_MUTE, MUTE_NOTCUE, 9'd0) :
                                 mk(K_FINAL, MODE_NONE, 9'd0);
                    default: o = mk(K_FINAL, MODE_NONE, 9'd0);
                endcase
            end
            SEQ_FFFD, SEQ_FREW:
            begin
                unique case (step)
                    5'd1:    o = mk(K_LIFT, 4'd1, 9'd100);
                    5'd2:    o = mk(K_SPOOL, (seq == SEQ_FFFD) ? 4'd4 : 4'd5, 9'd0);
                    5'd3:    o = mk(K_AS, (seq == SEQ_FFFD) ?
                                    4'(AS_FFD) : 4'(AS_REW), 9'd0);
                    default: o = mk(K_FINAL, MODE_NONE, 9'd0);
                endcase
            end
            MODE_CAPF, MODE_CAPR:
            begin
                unique case (step)
                    5'd1:    o = mk(K_MUTE, 4'd1, 9'd10);
                    5'd2:    o = (seq == MODE_CAPF) ? mk(K_CAP, 4'd0, 9'd10) :
                                 mk(K_CAP, 4'd1, 9'd0);
                    5'd3:    o = mk(K_WCAP, 4'd0, 9'd0);
                    5'd4:    o = mk(K_MUTE, MUTE_NOTCUE, 9'd0);
                    default: o = mk(K_FINAL, MODE_NONE, 9'd0);
                endcase
            end
            MODE_ASTOP:
            begin
                unique case (step)
                    5'd1:    o = mk(K_MUTE, 4'd1, 9'd10);
                    5'd2:    o = mk(K_PRESS, 4'd0, 9'd0);
                    5'd3:    o = mk(K_SPOOL, 4'd1, 9'd0);
                    5'd4:    o = mk(K_BRAKE, 4'd0, 9'd0);
                    5'd5:    o = mk(K_WSTOP, 4'd0, 9'd0);
                    5'd6:    o = mk(K_AS, 4'(AS_OFF), 9'd0);
                    5'd7:    o = mk(K_LIFT, 4'd0, 9'd50);
                    5'd8:    o = mk(K_SPOOL, 4'd0, 9'd0);
                    default: o = mk(K_FINAL, MODE_STOP, 9'd0);
                endcase
            end
            default: o = mk(K_FINAL, MODE_NONE, 9'd0);
        endcase
        return o;
    endfunction

endpackage

@@ rtl/tape_transport_mode_sequencer_unit.sv @@
// A request's result is computed combinationally and registered in the result register, or
// in the skid register while the output stalls. One request per cycle is taken while in_stall
// is low; the sequencer step, timers and autostop check all settle combinationally between the
// request and the result register. A two-entry output stage (result plus skid register) lets
// requests keep flowing while a result waits. Asynchronous active-low reset returns the transport
// to stop, muted, with all timers expired and the state and configuration registers at defaults.
module tape_transport_mode_sequencer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [3:0]                      mode_request,
    input  logic                            cue_on,
    input  logic                            tape_present,
    input  logic                            tape_moving,
    input  logic                            low_tension_left,
    input  logic                            low_tension_right,
    input  logic                            capstan_ready,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            press_on,
    output logic                            brake_on,
    output logic                            lift_on,
    output logic                            capstan_reverse,
    output logic [2:0]                      spool_mode,
    output logic                            mute_on,
    output logic [3:0]                      active_mode,
    output logic                            autostop_trip,
    output logic                            low_tension
);
    import ttms_pkg::*;

    // Configuration registers.
    logic [3:0]             enables_reg;
    logic [15:0]            pretens_delay_reg, tension_delay_reg, brake_delay_reg;

    // Sequencer state.
    logic [3:0]             settled_reg, settled_next;
    logic [3:0]             target_reg, target_next;
    logic [3:0]             accepted_reg, accepted_next;
    logic [3:0]             running_reg, running_next;
    logic [4:0]             step_reg, step_next;
    logic [DELAY_WIDTH-1:0] op_delay_reg, op_delay_next;
    logic [DELAY_WIDTH-1:0] as_timer_reg, as_timer_next;
    logic [DELAY_WIDTH-1:0] brake_timer_reg, brake_timer_next;
    logic [2:0]             as_mode_reg, as_mode_next;
    logic                   braking_reg, braking_next;
    logic                   tape_seen_reg, tape_seen_next;
    logic                   low_ten_reg, low_ten_next;
    logic                   cue_reg, cue_next;

    // Actuator state.
    logic                   press_reg, press_next;
    logic                   brake_reg, brake_next;
    logic                   lift_reg, lift_next;
    logic                   rev_reg, rev_next;
    logic [2:0]             spool_reg, spool_next;
    logic                   mute_reg, mute_next;

    // Output stage.
    logic                   out_valid_reg, skid_valid_reg;
    result_t                out_res_reg, skid_res_reg, res_next;

    // Working signals of the step logic.
    logic                   acc;
    logic                   as_go;
    logic [2:0]             as_arg;
    logic                   trip;
    logic                   fas;
    logic                   op_done;
    logic                   want;
    seq_op_t                op;

    assign acc      = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Process one request: sequencer step, cue and mode handling, autostop check.
    always_comb
    begin
        settled_next     = settled_reg;
        target_next      = target_reg;
        accepted_next    = accepted_reg;
        running_next     = running_reg;
        step_next        = step_reg;
        op_delay_next    = op_delay_reg;
        as_timer_next    = as_timer_reg;
        brake_timer_next = brake_timer_reg;
        as_mode_next     = as_mode_reg;
        braking_next     = braking_reg;
        tape_seen_next   = tape_seen_reg;
        low_ten_next     = low_ten_reg;
        cue_next         = cue_reg;
        press_next       = press_reg;
        brake_next       = brake_reg;
        lift_next        = lift_reg;
        rev_next         = rev_reg;
        spool_next       = spool_reg;
        mute_next        = mute_reg;
        as_go            = 1'b0;
        as_arg           = as_mode_reg;
        trip             = 1'b0;
        fas              = 1'b0;
        op_done          = 1'b0;
        want             = 1'b0;
        op               = seq_rom(running_reg, step_reg);

        case (action)
            ACT_TICK:
            begin
                // Timers count down first.
                if (op_delay_next != '0)
                    op_delay_next = op_delay_next - 1'b1;
                if (as_timer_next != '0)
                    as_timer_next = as_timer_next - 1'b1;
                if (brake_timer_next != '0)
                    brake_timer_next = brake_timer_next - 1'b1;

                // Sequencer: start a new sequence on a fresh target, then run one step.
                if (settled_reg != target_reg)
                begin
                    if (accepted_reg != target_reg)
                    begin
                        if (settled_reg == MODE_AFFD && target_reg == MODE_FFD)
                            running_next = SEQ_FFFD;
                        else if (settled_reg == MODE_AREW && target_reg == MODE_REW)
                            running_next = SEQ_FREW;
                        else
                            running_next = target_reg;
                        accepted_next = target_reg;
                        settled_next  = MODE_NONE;
                        step_next     = 5'd1;
                    end
                    op = seq_rom(running_next, step_next);
                    if (op_delay_next == '0 && step_next >= 5'd1 &&
                        step_next <= seq_len(running_next))
                    begin
                        op_done = 1'b1;
                        want    = op.arg[0];
                        case (op.kind)
                            K_MUTE:
                            begin
                                if (op.arg == MUTE_NOTCUE)
                                    want = !cue_reg;
                                if (mute_next != want)
                                begin
                                    mute_next     = want;
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_CAP:
                            begin
                                if (rev_next != want)
                                begin
                                    rev_next      = want;
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_PRESS:
                            begin
                                if (press_next != want)
                                begin
                                    press_next    = want;
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_BRAKE:
                            begin
                                if (brake_next != want)
                                begin
                                    brake_next    = want;
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_LIFT:
                            begin
                                if (cue_reg)
                                    want = 1'b0;
                                if (lift_next != want)
                                begin
                                    lift_next     = want;
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_SPOOL:
                            begin
                                if (4'(spool_next) != op.arg)
                                begin
                                    spool_next    = op.arg[2:0];
                                    op_delay_next = sat_load(16'(op.del));
                                end
                            end
                            K_AS:
                            begin
                                as_go         = 1'b1;
                                as_arg        = op.arg[2:0];
                                op_delay_next = sat_load(16'(op.del));
                            end
                            K_WSTOP:
                                op_done = !tape_moving || low_ten_reg;
                            K_WTEN:
                                op_done = (!low_tension_left && !low_tension_right) ||
                                          !enables_reg[0];
                            K_WCAP:
                                op_done = capstan_ready;
                            K_FINAL:
                            begin
                                accepted_next = MODE_NONE;
                                if (op.arg != MODE_NONE)
                                    target_next = op.arg;
                                settled_next = target_next;
                            end
                            default: op_done = 1'b1;
                        endcase
                        if (op_done)
                            step_next = step_next + 5'd1;
                    end
                end
            end
            ACT_MODE:
            begin
                // A known mode becomes the target; capstan modes keep the cue state.
                if (mode_request <= MODE_ASTOP)
                begin
                    target_next = mode_request;
                    if (mode_request != MODE_CAPF && mode_request != MODE_CAPR)
                    begin
                        if (mode_request == MODE_AFFD || mode_request == MODE_AREW)
                            lift_next = 1'b1;
                        mute_next = 1'b1;
                        as_go     = 1'b1;
                        cue_next  = 1'b0;
                    end
                end
            end
            ACT_CUE:
            begin
                if (cue_on)
                begin
                    if (target_reg == MODE_AFFD || target_reg == MODE_AREW)
                        lift_next = 1'b0;
                    if (settled_reg == target_reg)
                        mute_next = 1'b0;
                end
                else
                begin
                    if (target_reg == MODE_AFFD || target_reg == MODE_AREW)
                        lift_next = 1'b1;
                    mute_next = 1'b1;
                end
                as_go    = 1'b1;
                cue_next = cue_on;
            end
            default:
            begin
                // Unknown action leaves the state as it is.
            end
        endcase

        // Autostop mode change.
        if (as_go)
        begin
            braking_next = 1'b0;
            case (as_arg)
                AS_OFF:
                    as_mode_next = AS_OFF;
                AS_SPINUP:
                begin
                    as_timer_next = sat_load(pretens_delay_reg);
                    as_mode_next  = AS_SPINUP;
                end
                AS_PLAY, AS_FFD, AS_REW:
                begin
                    as_timer_next  = sat_load(tension_delay_reg);
                    tape_seen_next = tape_present;
                    as_mode_next   = as_arg;
                end
                AS_BRAKING:
                begin
                    brake_timer_next = sat_load(brake_delay_reg);
                    as_timer_next    = sat_load(tension_delay_reg);
                    braking_next     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Autostop check on ticks.
        if (action == ACT_TICK)
        begin
            case (as_mode_next)
                AS_SPINUP:
                begin
                    low_ten_next = low_tension_left || low_tension_right;
                    fas = low_ten_next && enables_reg[0];
                end
                AS_PLAY:
                begin
                    low_ten_next = low_tension_left || low_tension_right;
                    fas = low_ten_next && enables_reg[1];
                end
                AS_FFD:
                begin
                    low_ten_next = low_tension_right;
                    fas = low_ten_next && enables_reg[1];
                end
                AS_REW:
                begin
                    low_ten_next = low_tension_left;
                    fas = low_ten_next && enables_reg[1];
                end
                default:
                    low_ten_next = low_tension_left || low_tension_right;
            endcase
            if (fas && as_timer_next == '0)
                trip = 1'b1;
            else if (braking_next && tape_moving && brake_timer_next == '0 &&
                     enables_reg[3])
                trip = 1'b1;
            else if (as_mode_next > AS_SPINUP)
            begin
                if (tape_seen_next && !tape_present)
                    trip = 1'b1;
                else
                begin
                    tape_seen_next = tape_present;
                    if (!tape_moving && !braking_next && as_timer_next == '0 &&
                        enables_reg[2])
                        trip = 1'b1;
                end
            end
        end

        res_next.press   = press_next;
        res_next.brake   = brake_next;
        res_next.lift    = lift_next;
        res_next.reverse = rev_next;
        res_next.spool   = spool_next;
        res_next.mute    = mute_next;
        res_next.active  = settled_next;
        res_next.trip    = trip;
        res_next.low_ten = low_ten_next;
    end

    // State and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg       <= 4'd15;
            pretens_delay_reg <= 16'd1000;
            tension_delay_reg <= 16'd1000;
            brake_delay_reg   <= 16'd3000;
            settled_reg       <= MODE_STOP;
            target_reg        <= MODE_STOP;
            accepted_reg      <= MODE_STOP;
            running_reg       <= MODE_STOP;
            step_reg          <= 5'd1;
            op_delay_reg      <= '0;
            as_timer_reg      <= '0;
            brake_timer_reg   <= '0;
            as_mode_reg       <= AS_OFF;
            braking_reg       <= 1'b0;
            tape_seen_reg     <= 1'b0;
            low_ten_reg       <= 1'b0;
            cue_reg           <= 1'b0;
            press_reg         <= 1'b0;
            brake_reg         <= 1'b0;
            lift_reg          <= 1'b0;
            rev_reg           <= 1'b0;
            spool_reg         <= 3'd0;
            mute_reg          <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENABLES: enables_reg       <= cfg_data[3:0];
                    REG_PRETENS: pretens_delay_reg <= cfg_data;
                    REG_TENSION: tension_delay_reg <= cfg_data;
                    REG_BRAKE:   brake_delay_reg   <= cfg_data;
                    default:     enables_reg       <= enables_reg;
                endcase
            end
            if (acc)
            begin
                settled_reg     <= settled_next;
                target_reg      <= target_next;
                accepted_reg    <= accepted_next;
                running_reg     <= running_next;
                step_reg        <= step_next;
                op_delay_reg    <= op_delay_next;
                as_timer_reg    <= as_timer_next;
                brake_timer_reg <= brake_timer_next;
                as_mode_reg     <= as_mode_next;
                braking_reg     <= braking_next;
                tape_seen_reg   <= tape_seen_next;
                low_ten_reg     <= low_ten_next;
                cue_reg         <= cue_next;
                press_reg       <= press_next;
                brake_reg       <= brake_next;
                lift_reg        <= lift_next;
                rev_reg         <= rev_next;
                spool_reg       <= spool_next;
                mute_reg        <= mute_next;
            end
        end
    end

    // Output stage control: result register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= acc;
        end
        else if (acc)
            skid_valid_reg <= 1'b1;
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (acc)
                out_res_reg <= res_next;
        end
        else if (acc)
            skid_res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign press_on        = out_res_reg.press;
    assign brake_on        = out_res_reg.brake;
    assign lift_on         = out_res_reg.lift;
    assign capstan_reverse = out_res_reg.reverse;
    assign spool_mode      = out_res_reg.spool;
    assign mute_on         = out_res_reg.mute;
    assign active_mode     = out_res_reg.active;
    assign autostop_trip   = out_res_reg.trip;
    assign low_tension     = out_res_reg.low_ten;

    // A post delay only runs while the transport is switching.
    a_delay_switching: assert property (@(posedge clk) disable iff (!rst_n)
        (op_delay_reg != '0) |-> (settled_reg == MODE_NONE))
        else $error("post delay pending in a settled mode");

    // Requests other than ticks leave the operation delay untouched.
    a_no_count_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && action != ACT_TICK) |=> $stable(op_delay_reg))
        else $error("operation delay changed on a non-tick request");

    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output empty");

endmodule
